// File: hdl/mtn_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtn_pkg
// Shared types, character codes and constants for the melody text note
// decoder: item structs, parser modes, queued commands and the tone table.
// ----------------------------------------------------------------------------
package mtn_pkg;

  localparam int LENGTH_BITS_DEF = 16;
  // The base length reset value needs this many bits.
  localparam int LEN_RESET_W     = 11;
  localparam int LEN_RESET       = 1500;

  localparam int QDEPTH = 4;
  localparam int QPTR_W = 2;
  localparam int QCNT_W = 3;

  localparam int TONE_W = 12;
  localparam int FREQ_W = 13;
  localparam int DUR_W  = 17;
  localparam int MUL_W  = 22;
  localparam int PROD_W = 43;

  localparam logic [10:0] SHARP_MUL   = 11'd1059;
  // Reciprocal of 1000 scaled by 2^30; exact for all products below 2^22.
  localparam logic [20:0] RECIP_1000  = 21'd1073742;

  localparam logic [2:0] OCT_RESET   = 3'd4;
  localparam logic [2:0] OCT_MIN     = 3'd1;
  localparam logic [2:0] OCT_MAX     = 3'd7;
  localparam logic [5:0] METER_RESET = 6'd4;
  localparam logic [2:0] NOTE_REST   = 3'd7;
  localparam int         METER_LIMIT = 64;

  localparam logic [7:0] CH_HASH   = 8'h23;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_PLUS   = 8'h2B;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_0      = 8'h30;
  localparam logic [7:0] CH_1      = 8'h31;
  localparam logic [7:0] CH_7      = 8'h37;
  localparam logic [7:0] CH_9      = 8'h39;
  localparam logic [7:0] CH_COLON  = 8'h3A;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_AT     = 8'h40;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_G   = 8'h47;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_G   = 8'h67;

  // Seventh-octave frequencies for a..g, then the rest.
  localparam logic [TONE_W-1:0] TONE_TABLE [8] = '{
    12'd3520, 12'd3951, 12'd2093, 12'd2349, 12'd2637, 12'd2794, 12'd3136, 12'd0
  };

  typedef enum logic [1:0] {
    KIND_NOTE   = 2'd0,
    KIND_REWIND = 2'd1,
    KIND_END    = 2'd2
  } result_kind_t;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_OCT,
    MODE_LEN,
    MODE_MET,
    MODE_NOTE,
    MODE_SHARP,
    MODE_DIG
  } parse_mode_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_CALC,
    B_DONE
  } back_state_t;

  typedef struct packed {
    logic [7:0] text_char;
    logic       start_of_text;
    logic       end_of_text;
  } text_item_t;

  typedef struct packed {
    result_kind_t      result_kind;
    logic [FREQ_W-1:0] tone_frequency;
    logic [DUR_W-1:0]  note_duration;
    logic              hold_forever;
    logic              last_result;
  } result_item_t;

  typedef struct packed {
    result_kind_t kind;
    logic [2:0]   note;
    logic [2:0]   octave;
    logic         sharp;
    logic [7:0]   meter;
    logic         dotted;
    logic         last;
  } cmd_t;

  // Up to two commands per item; a note, when present, is always first.
  typedef struct packed {
    logic first_valid;
    logic second_valid;
    cmd_t first;
    cmd_t second;
  } push_t;

endpackage
`default_nettype wire

// File: hdl/mtn_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtn_front
// Character parser. Keeps the base and pending note state and turns each
// accepted item into zero, one or two commands for the back end.
// ----------------------------------------------------------------------------
module mtn_front import mtn_pkg::*; #(
  parameter  int LENGTH_BITS = LENGTH_BITS_DEF,
  localparam int LEN_W = (LENGTH_BITS > LEN_RESET_W) ? LENGTH_BITS : LEN_RESET_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             take,
  input  text_item_t       item,
  output push_t            push,
  output logic [LEN_W-1:0] push_length
);

  parse_mode_t            mode, mode_next;
  logic [2:0]             base_oct, base_oct_next;
  logic [5:0]             cur_meter, cur_meter_next;
  logic [LEN_W-1:0]       base_len, base_len_next;
  logic [2:0]             pend_note, pend_note_next;
  logic [2:0]             pend_oct, pend_oct_next;
  logic                   pend_sharp, pend_sharp_next;
  logic [7:0]             pend_meter, pend_meter_next;
  logic [LENGTH_BITS-1:0] accum, accum_next;
  logic                   ovf, ovf_next;

  logic [7:0]             c;
  logic [3:0]             digit;
  logic                   is_dig, is_lower, is_upper;
  logic [LENGTH_BITS+3:0] acc_sum;
  logic [7:0]             meter_sum;
  logic                   len_ok, met_ok;
  parse_mode_t            mode_cur;
  logic                   note_emit, note_dot, other_emit, idle_run;
  result_kind_t           other_kind;
  cmd_t                   note_cmd, other_cmd;

  assign c        = item.text_char;
  assign digit    = c[3:0];
  assign is_dig   = (c >= CH_0) && (c <= CH_9);
  assign is_lower = (c >= CH_LO_A) && (c <= CH_LO_G);
  assign is_upper = (c >= CH_UP_A) && (c <= CH_UP_G);

  assign acc_sum = ((LENGTH_BITS+4)'(accum) << 3) + ((LENGTH_BITS+4)'(accum) << 1)
                 + (LENGTH_BITS+4)'(digit);
  assign meter_sum = 8'((11'(pend_meter) << 3) + (11'(pend_meter) << 1) + 11'(digit));

  assign len_ok = !ovf && (accum != '0);
  assign met_ok = len_ok && (accum < LENGTH_BITS'(METER_LIMIT));

  always_comb begin
    mode_next       = mode;
    base_oct_next   = base_oct;
    cur_meter_next  = cur_meter;
    base_len_next   = base_len;
    pend_note_next  = pend_note;
    pend_oct_next   = pend_oct;
    pend_sharp_next = pend_sharp;
    pend_meter_next = pend_meter;
    accum_next      = accum;
    ovf_next        = ovf;
    note_emit       = 1'b0;
    note_dot        = 1'b0;
    other_emit      = 1'b0;
    other_kind      = KIND_END;
    idle_run        = 1'b0;
    mode_cur        = mode;

    if (item.start_of_text) begin
      base_oct_next   = OCT_RESET;
      cur_meter_next  = METER_RESET;
      base_len_next   = LEN_W'(LEN_RESET);
      mode_next       = MODE_IDLE;
      mode_cur        = MODE_IDLE;
      accum_next      = '0;
      ovf_next        = 1'b0;
    end

    if (item.end_of_text) begin
      if (mode_cur == MODE_LEN) begin
        if (len_ok) base_len_next = LEN_W'(accum);
      end else if (mode_cur == MODE_MET) begin
        if (met_ok) cur_meter_next = accum[5:0];
      end else if (mode_cur == MODE_NOTE || mode_cur == MODE_SHARP ||
                   mode_cur == MODE_DIG) begin
        note_emit = 1'b1;
      end
      mode_next  = MODE_IDLE;
      other_emit = 1'b1;
      other_kind = KIND_END;
    end else begin
      unique case (mode_cur)
        MODE_OCT: begin
          mode_next = MODE_IDLE;
          if (c >= CH_1 && c <= CH_7) base_oct_next = c[2:0];
          else idle_run = 1'b1;
        end
        MODE_LEN, MODE_MET: begin
          if (is_dig) begin
            if (!ovf) begin
              if (acc_sum[LENGTH_BITS+3:LENGTH_BITS] != 4'd0) ovf_next = 1'b1;
              else accum_next = acc_sum[LENGTH_BITS-1:0];
            end
          end else begin
            if (mode_cur == MODE_LEN) begin
              if (len_ok) base_len_next = LEN_W'(accum);
            end else begin
              if (met_ok) cur_meter_next = accum[5:0];
            end
            idle_run = 1'b1;
          end
        end
        MODE_NOTE, MODE_SHARP, MODE_DIG: begin
          if (mode_cur == MODE_NOTE && c == CH_PLUS) begin
            if (pend_oct < OCT_MAX) pend_oct_next = pend_oct + 3'd1;
          end else if (mode_cur == MODE_NOTE && c == CH_MINUS) begin
            if (pend_oct > OCT_MIN) pend_oct_next = pend_oct - 3'd1;
          end else if (mode_cur == MODE_NOTE && c == CH_HASH) begin
            pend_sharp_next = 1'b1;
            mode_next       = MODE_SHARP;
          end else if (is_dig) begin
            pend_meter_next = (mode_cur == MODE_DIG) ? meter_sum : 8'(digit);
            mode_next       = MODE_DIG;
          end else if (c == CH_DOT) begin
            note_emit = 1'b1;
            note_dot  = 1'b1;
            mode_next = MODE_IDLE;
          end else begin
            note_emit = 1'b1;
            idle_run  = 1'b1;
          end
        end
        MODE_IDLE: idle_run = 1'b1;
        default:   idle_run = 1'b1;
      endcase
    end

    if (idle_run) begin
      mode_next = MODE_IDLE;
      if (c == CH_AT) begin
        other_emit = 1'b1;
        other_kind = KIND_REWIND;
      end else if (c == CH_EQ) begin
        mode_next = MODE_OCT;
      end else if (c == CH_PLUS) begin
        if (base_oct_next < OCT_MAX) base_oct_next = base_oct_next + 3'd1;
      end else if (c == CH_MINUS) begin
        if (base_oct_next > OCT_MIN) base_oct_next = base_oct_next - 3'd1;
      end else if (c == CH_COLON || c == CH_SLASH) begin
        mode_next  = (c == CH_COLON) ? MODE_LEN : MODE_MET;
        accum_next = '0;
        ovf_next   = 1'b0;
      end else if (is_lower || is_upper || c == CH_DOLLAR) begin
        pend_oct_next   = base_oct_next;
        pend_sharp_next = 1'b0;
        pend_meter_next = 8'(cur_meter_next);
        if (c == CH_DOLLAR) begin
          pend_note_next = NOTE_REST;
        end else if (is_lower) begin
          pend_note_next = 3'(c - CH_LO_A);
        end else begin
          pend_note_next = 3'(c - CH_UP_A);
          if (base_oct_next < OCT_MAX) pend_oct_next = base_oct_next + 3'd1;
        end
        mode_next = MODE_NOTE;
      end
    end
  end

  always_comb begin
    note_cmd.kind   = KIND_NOTE;
    note_cmd.note   = pend_note;
    note_cmd.octave = pend_oct;
    note_cmd.sharp  = pend_sharp;
    note_cmd.meter  = pend_meter;
    note_cmd.dotted = note_dot;
    note_cmd.last   = !other_emit;

    other_cmd.kind   = other_kind;
    other_cmd.note   = 3'd0;
    other_cmd.octave = 3'd0;
    other_cmd.sharp  = 1'b0;
    other_cmd.meter  = 8'd0;
    other_cmd.dotted = 1'b0;
    other_cmd.last   = 1'b1;

    push.first_valid  = take && (note_emit || other_emit);
    push.second_valid = take && note_emit && other_emit;
    push.first        = note_emit ? note_cmd : other_cmd;
    push.second       = other_cmd;
  end

  // A note always uses the base length held before this item.
  assign push_length = base_len;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      base_oct   <= OCT_RESET;
      cur_meter  <= METER_RESET;
      base_len   <= LEN_W'(LEN_RESET);
      pend_note  <= 3'd0;
      pend_oct   <= OCT_RESET;
      pend_sharp <= 1'b0;
      pend_meter <= 8'(METER_RESET);
      accum      <= '0;
      ovf        <= 1'b0;
    end else if (take) begin
      mode       <= mode_next;
      base_oct   <= base_oct_next;
      cur_meter  <= cur_meter_next;
      base_len   <= base_len_next;
      pend_note  <= pend_note_next;
      pend_oct   <= pend_oct_next;
      pend_sharp <= pend_sharp_next;
      pend_meter <= pend_meter_next;
      accum      <= accum_next;
      ovf        <= ovf_next;
    end
  end

endmodule
`default_nettype wire

// File: hdl/mtn_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtn_queue
// Short command queue between parser and back end. Takes up to two commands
// in a cycle and hands out one; room means at least two free entries.
// ----------------------------------------------------------------------------
module mtn_queue import mtn_pkg::*; #(
  parameter  int LENGTH_BITS = LENGTH_BITS_DEF,
  localparam int LEN_W = (LENGTH_BITS > LEN_RESET_W) ? LENGTH_BITS : LEN_RESET_W
) (
  input  logic             clk,
  input  logic             rst,
  input  push_t            push,
  input  logic [LEN_W-1:0] push_length,
  input  logic             pop,
  output logic             head_valid,
  output cmd_t             head,
  output logic [LEN_W-1:0] head_length,
  output logic             room
);

  cmd_t              q_cmd [QDEPTH];
  logic [LEN_W-1:0]  q_len [QDEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr, wr_ptr_alt;
  logic [QCNT_W-1:0] count;

  assign wr_ptr_alt  = wr_ptr + QPTR_W'(1);
  assign head_valid  = (count != '0);
  assign head        = q_cmd[rd_ptr];
  assign head_length = q_len[rd_ptr];
  assign room        = (count <= QCNT_W'(QDEPTH - 2));

  always_ff @(posedge clk) begin
    if (push.first_valid) begin
      q_cmd[wr_ptr] <= push.first;
      q_len[wr_ptr] <= push_length;
    end
    if (push.second_valid) begin
      q_cmd[wr_ptr_alt] <= push.second;
      q_len[wr_ptr_alt] <= push_length;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + QPTR_W'(push.first_valid) + QPTR_W'(push.second_valid);
      rd_ptr <= rd_ptr + QPTR_W'(pop);
      count  <= count + QCNT_W'(push.first_valid) + QCNT_W'(push.second_valid)
              - QCNT_W'(pop);
    end
  end

endmodule
`default_nettype wire

// File: hdl/mtn_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// mtn_back
// Note builder. Takes one command at a time, divides the base length by the
// meter one quotient bit per cycle, scales the tone for a sharp in a short
// multiplier pipeline, and holds the finished item in an output register.
// ----------------------------------------------------------------------------
module mtn_back import mtn_pkg::*; #(
  parameter  int LENGTH_BITS = LENGTH_BITS_DEF,
  localparam int LEN_W = (LENGTH_BITS > LEN_RESET_W) ? LENGTH_BITS : LEN_RESET_W,
  localparam int CNT_W = $clog2(LEN_W)
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             head_valid,
  input  cmd_t             head,
  input  logic [LEN_W-1:0] head_length,
  output logic             pop,
  output result_item_t     result_item,
  output logic             result_valid,
  input  logic             result_stall
);

  back_state_t       state, state_next;
  logic              load_res;
  cmd_t              cmd;
  logic [LEN_W-1:0]  quo;
  logic [7:0]        rem, rem_step;
  logic [CNT_W-1:0]  cnt;
  logic [8:0]        trial, diff;
  logic              q_bit;
  logic [2:0]        oct_c;
  logic [TONE_W-1:0] f_base;
  logic [MUL_W-1:0]  f_mul;
  logic [PROD_W-1:0] f_prod;
  logic [FREQ_W-1:0] f_sharp;
  logic [LEN_W:0]    dsum;
  logic              hold;
  result_item_t      res_next;

  always_ff @(posedge clk) begin
    if (rst) state <= B_IDLE;
    else     state <= state_next;
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    load_res   = 1'b0;
    unique case (state)
      B_IDLE: begin
        if (head_valid) begin
          pop        = 1'b1;
          state_next = B_CALC;
        end
      end
      B_CALC: begin
        if (cnt == CNT_W'(LEN_W - 1)) state_next = B_DONE;
      end
      B_DONE: begin
        if (!result_valid || !result_stall) begin
          load_res   = 1'b1;
          state_next = B_IDLE;
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  // Restoring division: the remainder stays below the 8-bit meter whenever the meter is nonzero.
  assign trial    = {rem, quo[LEN_W-1]};
  assign diff     = trial - {1'b0, cmd.meter};
  assign q_bit    = (trial >= {1'b0, cmd.meter});
  assign rem_step = q_bit ? diff[7:0] : trial[7:0];

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd <= head;
      quo <= head_length;
      rem <= 8'd0;
      cnt <= '0;
    end else if (state == B_CALC) begin
      rem <= rem_step;
      quo <= {quo[LEN_W-2:0], q_bit};
      cnt <= cnt + CNT_W'(1);
    end
  end

  // The tone pipeline registers f_base, f_mul and f_sharp in turn after a load
  // and settles well before the divider finishes.
  assign oct_c  = (cmd.octave < OCT_MIN) ? OCT_MIN : cmd.octave;
  assign f_prod = PROD_W'(f_mul) * PROD_W'(RECIP_1000);

  always_ff @(posedge clk) begin
    f_base  <= TONE_TABLE[cmd.note] >> (OCT_MAX - oct_c);
    f_mul   <= MUL_W'(f_base) * MUL_W'(SHARP_MUL);
    f_sharp <= f_prod[PROD_W-1:30];
  end

  assign dsum = {1'b0, quo} + (cmd.dotted ? {2'b00, quo[LEN_W-1:1]} : '0);
  assign hold = (cmd.meter == 8'd0);

  always_comb begin
    res_next.result_kind    = cmd.kind;
    res_next.tone_frequency = '0;
    res_next.note_duration  = '0;
    res_next.hold_forever   = 1'b0;
    res_next.last_result    = cmd.last;
    if (cmd.kind == KIND_NOTE) begin
      res_next.tone_frequency = cmd.sharp ? f_sharp : FREQ_W'(f_base);
      res_next.hold_forever   = hold;
      res_next.note_duration  = hold ? '0 : DUR_W'(dsum);
    end
  end

  always_ff @(posedge clk) begin
    if (load_res) result_item <= res_next;
  end

  always_ff @(posedge clk) begin
    if (rst)               result_valid <= 1'b0;
    else if (load_res)     result_valid <= 1'b1;
    else if (!result_stall) result_valid <= 1'b0;
  end

endmodule
`default_nettype wire

// File: hdl/melody_text_note_decoder.sv
`default_nettype none
// With the back end idle, an item that causes a note is written to the queue,
// popped into the back end, run through the bit-serial length divider for all
// LEN_W quotient bits, with LEN_W the larger of LENGTH_BITS and 11 (16 at the
// default), then loaded into the result register. The parser takes one item a
// cycle while the queue has room; the back end builds one result at a time.
// Reset: synchronous; base octave 4, meter 4, length 1500, queue empty.
// ----------------------------------------------------------------------------
// melody_text_note_decoder
// Parses melody text into notes, rewind marks and end marks. A parser front
// end feeds a short command queue drained by a note-building back end.
// ----------------------------------------------------------------------------
module melody_text_note_decoder import mtn_pkg::*; #(
  parameter  int LENGTH_BITS = LENGTH_BITS_DEF,
  localparam int LEN_W = (LENGTH_BITS > LEN_RESET_W) ? LENGTH_BITS : LEN_RESET_W
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         text_valid,
  output logic         text_stall,
  input  text_item_t   text_item,
  output logic         result_valid,
  input  logic         result_stall,
  output result_item_t result_item
);

  logic             take;
  push_t            push;
  logic [LEN_W-1:0] push_length;
  logic             pop;
  logic             head_valid;
  cmd_t             head;
  logic [LEN_W-1:0] head_length;
  logic             room;

  assign text_stall = !room;
  assign take       = text_valid && room;

  mtn_front #(.LENGTH_BITS(LENGTH_BITS)) u_front (
    .clk         (clk),
    .rst         (rst),
    .take        (take),
    .item        (text_item),
    .push        (push),
    .push_length (push_length)
  );

  mtn_queue #(.LENGTH_BITS(LENGTH_BITS)) u_queue (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .push_length (push_length),
    .pop         (pop),
    .head_valid  (head_valid),
    .head        (head),
    .head_length (head_length),
    .room        (room)
  );

  mtn_back #(.LENGTH_BITS(LENGTH_BITS)) u_back (
    .clk          (clk),
    .rst          (rst),
    .head_valid   (head_valid),
    .head         (head),
    .head_length  (head_length),
    .pop          (pop),
    .result_item  (result_item),
    .result_valid (result_valid),
    .result_stall (result_stall)
  );

endmodule
`default_nettype wire

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// Melody text note decoder testbench
// Streams melody text into the decoder, predicts every note, rewind and end
// mark in step with the accepted characters, and checks each result as it
// leaves the block under random sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module testbench;
  import mtn_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int RANDOM_ITEMS = 650;
  localparam int SETTLE_CYCLES = 64;
  localparam int LEN_MAX = (1 << LENGTH_BITS_DEF) - 1;

  typedef struct {
    text_item_t item;
    bit         wait_drain;
  } text_entry_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         text_valid = 1'b0;
  logic         text_stall;
  text_item_t   text_item = '0;
  logic         result_valid;
  logic         result_stall = 1'b0;
  result_item_t result_item;

  text_entry_t  text_queue[$];
  result_item_t notes_due[$];
  bit           pause_next;
  int           items_taken;
  int           total_items;
  int           cycles;
  int           errors;
  int           notes_seen;
  int           rewinds_seen;
  int           ends_seen;
  logic         steady;

  // Shadow of the decoder state.
  logic [2:0]                 base_oct;
  logic [5:0]                 cur_meter;
  logic [LENGTH_BITS_DEF-1:0] base_len;
  parse_mode_t                mode;
  logic [2:0]                 pend_note;
  logic [2:0]                 pend_oct;
  logic                       pend_sharp;
  logic [7:0]                 pend_meter;
  logic [16:0]                accum;
  logic                       accum_ovf;

  melody_text_note_decoder dut (
    .clk          (clk),
    .rst          (rst),
    .text_valid   (text_valid),
    .text_stall   (text_stall),
    .text_item    (text_item),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result_item  (result_item)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // No random sender gaps or receiver stalls through this stretch of the text.
  assign steady = (items_taken >= 300) && (items_taken < 430);

  function automatic int top_octave_hz(input logic [2:0] note);
    case (note)
      3'd0: return 3520;
      3'd1: return 3951;
      3'd2: return 2093;
      3'd3: return 2349;
      3'd4: return 2637;
      3'd5: return 2794;
      3'd6: return 3136;
      default: return 0;
    endcase
  endfunction

  function automatic bit is_digit(input logic [7:0] c);
    return (c >= CH_0) && (c <= CH_9);
  endfunction

  function automatic result_item_t mark_result(input result_kind_t kind);
    result_item_t r;
    r = '0;
    r.result_kind = kind;
    return r;
  endfunction

  function automatic result_item_t pending_note_result(input bit dotted);
    result_item_t r;
    int oct;
    int freq;
    int dur;
    oct = pend_oct;
    if (oct < 1) oct = 1;
    if (oct > 7) oct = 7;
    freq = top_octave_hz(pend_note) >> (7 - oct);
    if (pend_sharp) freq = freq * 1059 / 1000;
    r = '0;
    r.result_kind = KIND_NOTE;
    r.tone_frequency = FREQ_W'(freq);
    if (pend_meter == 8'd0) begin
      r.hold_forever = 1'b1;
    end else begin
      dur = int'(base_len) / int'(pend_meter);
      if (dotted) dur = dur * 3 / 2;
      r.note_duration = DUR_W'(dur);
    end
    return r;
  endfunction

  function automatic void apply_number();
    if (mode == MODE_LEN) begin
      if (!accum_ovf && accum > 0) base_len = LENGTH_BITS_DEF'(accum);
    end else if (mode == MODE_MET) begin
      if (!accum_ovf && accum > 0 && accum < 64) cur_meter = 6'(accum);
    end
  endfunction

  function automatic void reset_shadow();
    base_oct = 3'd4;
    cur_meter = 6'd4;
    base_len = LENGTH_BITS_DEF'(1500);
    mode = MODE_IDLE;
    pend_note = 3'd0;
    pend_oct = 3'd4;
    pend_sharp = 1'b0;
    pend_meter = 8'd4;
    accum = '0;
    accum_ovf = 1'b0;
  endfunction

  // Advances the shadow state by one character and queues what it emits.
  function automatic void decode_char(input text_item_t it);
    result_item_t got [2];
    int n;
    bit done;
    logic [7:0] c;
    int nxt;
    n = 0;
    done = 0;
    c = it.text_char;

    if (it.start_of_text) begin
      base_oct = 3'd4;
      cur_meter = 6'd4;
      base_len = LENGTH_BITS_DEF'(1500);
      mode = MODE_IDLE;
      accum = '0;
      accum_ovf = 1'b0;
    end

    if (it.end_of_text) begin
      if (mode == MODE_LEN || mode == MODE_MET) begin
        apply_number();
      end else if (mode == MODE_NOTE || mode == MODE_SHARP || mode == MODE_DIG) begin
        got[n] = pending_note_result(1'b0);
        n++;
      end
      mode = MODE_IDLE;
      got[n] = mark_result(KIND_END);
      n++;
      done = 1;
    end else begin
      case (mode)
        MODE_OCT: begin
          mode = MODE_IDLE;
          if (c >= CH_1 && c <= CH_7) begin
            base_oct = 3'(c - CH_0);
            done = 1;
          end
        end
        MODE_LEN, MODE_MET: begin
          if (is_digit(c)) begin
            if (!accum_ovf) begin
              nxt = int'(accum) * 10 + int'(c - CH_0);
              if (nxt > LEN_MAX) accum_ovf = 1'b1;
              else accum = 17'(nxt);
            end
            done = 1;
          end else begin
            apply_number();
            mode = MODE_IDLE;
          end
        end
        MODE_NOTE, MODE_SHARP, MODE_DIG: begin
          if (mode == MODE_NOTE && c == CH_PLUS) begin
            if (pend_oct < 3'd7) pend_oct++;
            done = 1;
          end else if (mode == MODE_NOTE && c == CH_MINUS) begin
            if (pend_oct > 3'd1) pend_oct--;
            done = 1;
          end else if (mode == MODE_NOTE && c == CH_HASH) begin
            pend_sharp = 1'b1;
            mode = MODE_SHARP;
            done = 1;
          end else if (is_digit(c)) begin
            if (mode == MODE_DIG) pend_meter = 8'(pend_meter * 10 + (c - CH_0));
            else pend_meter = 8'(c - CH_0);
            mode = MODE_DIG;
            done = 1;
          end else if (c == CH_DOT) begin
            got[n] = pending_note_result(1'b1);
            n++;
            mode = MODE_IDLE;
            done = 1;
          end else begin
            got[n] = pending_note_result(1'b0);
            n++;
            mode = MODE_IDLE;
          end
        end
        default: mode = MODE_IDLE;
      endcase
    end

    if (!done) begin
      mode = MODE_IDLE;
      if (c == CH_AT) begin
        got[n] = mark_result(KIND_REWIND);
        n++;
      end else if (c == CH_EQ) begin
        mode = MODE_OCT;
      end else if (c == CH_PLUS) begin
        if (base_oct < 3'd7) base_oct++;
      end else if (c == CH_MINUS) begin
        if (base_oct > 3'd1) base_oct--;
      end else if (c == CH_COLON || c == CH_SLASH) begin
        mode = (c == CH_COLON) ? MODE_LEN : MODE_MET;
        accum = '0;
        accum_ovf = 1'b0;
      end else if ((c >= CH_LO_A && c <= CH_LO_G) || (c >= CH_UP_A && c <= CH_UP_G) ||
                   c == CH_DOLLAR) begin
        pend_oct = base_oct;
        pend_sharp = 1'b0;
        pend_meter = 8'(cur_meter);
        if (c == CH_DOLLAR) begin
          pend_note = NOTE_REST;
        end else if (c >= CH_LO_A) begin
          pend_note = 3'(c - CH_LO_A);
        end else begin
          pend_note = 3'(c - CH_UP_A);
          if (pend_oct < 3'd7) pend_oct++;
        end
        mode = MODE_NOTE;
      end
    end

    if (n > 0) got[n-1].last_result = 1'b1;
    for (int i = 0; i < n; i++) notes_due.push_back(got[i]);
  endfunction

  task automatic push_char(input logic [7:0] c, input bit sot, input bit eot);
    text_entry_t e;
    e.item.text_char = c;
    e.item.start_of_text = sot;
    e.item.end_of_text = eot;
    e.wait_drain = pause_next;
    pause_next = 0;
    text_queue.push_back(e);
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_char(s[i], 1'b0, 1'b0);
  endtask

  task automatic push_digits(input int count);
    for (int i = 0; i < count; i++) push_char(8'(CH_0 + $urandom_range(0, 9)), 1'b0, 1'b0);
  endtask

  // Mostly well-formed melody text with random content, plus some noise.
  task automatic push_random_token();
    int sel;
    int pick;
    sel = $urandom_range(0, 99);
    if (sel < 40) begin
      pick = $urandom_range(0, 14);
      if (pick < 7) push_char(8'(CH_LO_A + pick), 1'b0, 1'b0);
      else if (pick < 14) push_char(8'(CH_UP_A + pick - 7), 1'b0, 1'b0);
      else push_char(CH_DOLLAR, 1'b0, 1'b0);
      repeat ($urandom_range(0, 3))
        push_char($urandom_range(0, 1) ? CH_PLUS : CH_MINUS, 1'b0, 1'b0);
      if ($urandom_range(0, 2) == 0) push_char(CH_HASH, 1'b0, 1'b0);
      if ($urandom_range(0, 1)) push_digits($urandom_range(1, 3));
      if ($urandom_range(0, 2) == 0) push_char(CH_DOT, 1'b0, 1'b0);
    end else if (sel < 50) begin
      push_char(CH_COLON, 1'b0, 1'b0);
      push_digits($urandom_range(1, 6));
    end else if (sel < 60) begin
      push_char(CH_SLASH, 1'b0, 1'b0);
      push_digits($urandom_range(1, 3));
    end else if (sel < 68) begin
      push_char(CH_EQ, 1'b0, 1'b0);
      if ($urandom_range(0, 3) != 0) push_digits(1);
      else push_char(8'($urandom_range(0, 255)), 1'b0, 1'b0);
    end else if (sel < 76) begin
      pick = $urandom_range(0, 1);
      repeat ($urandom_range(1, 7)) push_char(pick ? CH_PLUS : CH_MINUS, 1'b0, 1'b0);
    end else if (sel < 80) begin
      push_char(CH_AT, 1'b0, 1'b0);
    end else if (sel < 83) begin
      push_char(8'h20, 1'b0, 1'b0);
    end else if (sel < 87) begin
      push_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
    end else if (sel < 90) begin
      push_char(8'($urandom_range(0, 255)), 1'b1, 1'b0);
    end else begin
      push_char(8'($urandom_range(0, 255)), 1'($urandom_range(0, 7) == 0), 1'b0);
    end
  endtask

  // Sender: presents the next queued item unless it is idling or draining.
  always @(posedge clk) begin
    if (rst) begin
      text_valid <= 1'b0;
    end else begin
      if (text_valid && !text_stall) begin
        decode_char(text_item);
        items_taken++;
      end
      if (!text_valid || !text_stall) begin
        if (text_queue.size() > 0 &&
            !(text_queue[0].wait_drain && notes_due.size() > 0) &&
            (steady || $urandom_range(0, 99) >= 13)) begin
          text_item <= text_queue[0].item;
          text_valid <= 1'b1;
          void'(text_queue.pop_front());
        end else begin
          text_valid <= 1'b0;
        end
      end
    end
  end

  task automatic report_field(input string name, input int exp_val, input int got_val);
    $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, exp_val, got_val);
    errors++;
  endtask

  // Receiver: checks each accepted result against the oldest prediction.
  always @(posedge clk) begin
    result_item_t exp_r;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (notes_due.size() == 0) begin
          $display("%0t: unexpected result, expected none, got kind %0d freq %0d dur %0d",
                   $time, result_item.result_kind, result_item.tone_frequency,
                   result_item.note_duration);
          errors++;
        end else begin
          exp_r = notes_due.pop_front();
          if (result_item.result_kind !== exp_r.result_kind)
            report_field("result_kind", exp_r.result_kind, result_item.result_kind);
          if (result_item.tone_frequency !== exp_r.tone_frequency)
            report_field("tone_frequency", exp_r.tone_frequency, result_item.tone_frequency);
          if (result_item.note_duration !== exp_r.note_duration)
            report_field("note_duration", exp_r.note_duration, result_item.note_duration);
          if (result_item.hold_forever !== exp_r.hold_forever)
            report_field("hold_forever", exp_r.hold_forever, result_item.hold_forever);
          if (result_item.last_result !== exp_r.last_result)
            report_field("last_result", exp_r.last_result, result_item.last_result);
          case (exp_r.result_kind)
            KIND_NOTE:   notes_seen++;
            KIND_REWIND: rewinds_seen++;
            default:     ends_seen++;
          endcase
        end
      end
      result_stall <= !steady && ($urandom_range(0, 99) < 13);
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("%0t: timed out with %0d results outstanding", $time, notes_due.size());
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int directed_items;
    reset_shadow();

    // Upper-case letter clamped at octave 7, sharp, dotted, then a held rest
    // closed by a rewind.
    push_text("=7C+#1.$0@");
    // Overflowing length is rejected; meter 63 is kept; '-' ends the number.
    push_text(":99999/63-");
    // Meter digits wrap at 8 bits; the end of text flushes the note.
    push_text("g#999");
    push_char(8'hFF, 1'b0, 1'b1);
    push_char(CH_EQ, 1'b1, 1'b0);
    push_char(8'h00, 1'b0, 1'b0);
    // Dot on a zero meter keeps the hold; an unfinished '=' at the end.
    push_text("b0.=");
    push_char(CH_EQ, 1'b0, 1'b1);
    directed_items = text_queue.size();

    pause_next = 1;
    while (text_queue.size() < directed_items + RANDOM_ITEMS) begin
      if (text_queue.size() >= directed_items + RANDOM_ITEMS / 2 && text_queue.size() <
          directed_items + RANDOM_ITEMS / 2 + 4)
        pause_next = 1;
      push_random_token();
    end
    total_items = text_queue.size();

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    while (items_taken < total_items) @(posedge clk);
    while (notes_due.size() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d text items; checked %0d notes, %0d rewinds and %0d end marks.",
             items_taken, notes_seen, rewinds_seen, ends_seen);
    $display("Mismatches found: %0d", errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
